[design/linear_probing_hash_table_core_defines.svh]
// Assertion macros for the linear probing hash table core.
// Depends on nothing; the asserting module supplies clk and rst.
`ifndef LINEAR_PROBING_HASH_TABLE_CORE_DEFINES_SVH
`define LINEAR_PROBING_HASH_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LPHT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPHT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lpht_pkg.sv]
// Shared types and constants for the linear probing hash table core.
// Depends on nothing.
`timescale 1ns / 1ps

package lpht_pkg;

  localparam int KEY_W    = 32;
  localparam int ACT_W    = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;

  // Request actions.
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

  // Control states of the probe sequencer.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_RESP
  } state_t;

endpackage

[design/lpht_ram.sv]
// Generic single-port RAM with a registered read port (read-first).
// Depends on nothing.
`timescale 1ns / 1ps

module lpht_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle; the read returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[design/lpht_home.sv]
// Home slot unit: reduces a key modulo the table size.
// Depends on lpht_pkg. Power-of-two sizes take the low key bits; others register
// the key, then use a reciprocal multiply, a multiply back by the size and a subtract.
`timescale 1ns / 1ps

module lpht_home
  import lpht_pkg::*;
#(
  parameter int TABLE_SIZE = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [KEY_W-1:0]              key,
  output logic                          done,
  output logic [$clog2(TABLE_SIZE)-1:0] home
);

  localparam int IDX_W   = $clog2(TABLE_SIZE);
  localparam int MAGIC_W = KEY_W + 1;
  localparam int PROD_W  = KEY_W + MAGIC_W;
  localparam int QUOT_W  = PROD_W - KEY_W - IDX_W;
  localparam bit IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
  // Reciprocal rounded up, scaled so that the quotient is exact for every key.
  localparam logic [63:0] MAGIC_FULL =
    ((64'd1 << (KEY_W + IDX_W)) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE);
  localparam logic [MAGIC_W-1:0] MAGIC    = MAGIC_W'(MAGIC_FULL);
  localparam logic [KEY_W-1:0]   SIZE_EXT = KEY_W'(TABLE_SIZE);

  logic [2:0]        phase;
  logic [KEY_W-1:0]  key_q;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic [KEY_W-1:0]  qn;
  logic [IDX_W-1:0]  rem;

  // The quotient is the top of the scaled product.
  assign quot = prod[PROD_W-1 -: QUOT_W];

  // Control: a three-stage marker pipeline, done pulses once the remainder is final.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      done  <= 1'b0;
    end else begin
      phase <= {phase[1:0], start && !IS_POW2};
      done  <= IS_POW2 ? start : phase[2];
    end
  end

  // Datapath: product, quotient times size, then the remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      key_q <= key;
    end
    prod <= PROD_W'(key_q) * PROD_W'(MAGIC);
    qn   <= KEY_W'(quot) * SIZE_EXT;
    if (start && IS_POW2) begin
      rem <= key[IDX_W-1:0];
    end else if (phase[2]) begin
      rem <= IDX_W'(key_q - qn);
    end
  end

  assign home = rem;

endmodule

[design/linear_probing_hash_table_core.sv]
// Channel | signals                       | direction | payload
// in      | in_valid, in_ready            | to core   | action, key
// out     | out_valid, out_ready          | from core | status, slot
//
// After reset a clearing pass writes every slot invalid; no items are taken meanwhile.
// An item is accepted when idle, gets its home slot in the hash state, probes slots on the
// single RAM port until a hit or every slot is tried, then loads its result; an unknown action
// skips to the result. Probes are pipelined: one slot is read while the last is checked.
// A result waiting in the output register does not block the next item; the sequencer
// waits in its final state, taking nothing, only while that register is still full.
// Depends on lpht_pkg, lpht_home, lpht_ram and the defines header.
`timescale 1ns / 1ps
`include "linear_probing_hash_table_core_defines.svh"

module linear_probing_hash_table_core
  import lpht_pkg::*;
#(
  parameter int TABLE_SIZE = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACT_W-1:0]    action,
  input  logic [KEY_W-1:0]    key,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int MEM_W = KEY_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  state_t state, state_next;

  logic [ACT_W-1:0]    act, act_next;
  logic [KEY_W-1:0]    key_r, key_r_next;
  logic [IDX_W-1:0]    rd_idx, rd_idx_next;
  logic [IDX_W-1:0]    rd_step, rd_step_next;
  logic [IDX_W-1:0]    clr_idx, clr_idx_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [SLOT_W-1:0]   res_slot, res_slot_next;
  logic                out_valid_next;
  logic [STATUS_W-1:0] status_next;
  logic [SLOT_W-1:0]   slot_next;

  logic             hash_start;
  logic             hash_done;
  logic [IDX_W-1:0] hash_home;

  logic             mem_we;
  logic [IDX_W-1:0] mem_addr;
  logic [MEM_W-1:0] mem_wdata;
  logic [MEM_W-1:0] mem_rdata;

  logic             rd_vld;
  logic [KEY_W-1:0] rd_key;
  logic             hit;
  logic             last;
  logic             out_free;
  logic [IDX_W-1:0] next_idx;

  // Home slot reduction.
  lpht_home #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_home (
    .clk  (clk),
    .rst  (rst),
    .start(hash_start),
    .key  (key_r_next),
    .done (hash_done),
    .home (hash_home)
  );

  // Slot store: valid bit above the key.
  lpht_ram #(
    .WIDTH(MEM_W),
    .DEPTH(TABLE_SIZE)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // Probe decision on the slot read in the previous cycle.
  always_comb begin
    rd_vld   = mem_rdata[KEY_W];
    rd_key   = mem_rdata[KEY_W-1:0];
    hit      = (act == ACT_INSERT) ? !rd_vld : (rd_vld && (rd_key == key_r));
    last     = (rd_step == LAST_IDX);
    next_idx = (rd_idx == LAST_IDX) ? '0 : (rd_idx + 1'b1);
    out_free = !out_valid || out_ready;
  end

  // Next state, memory access and register updates.
  always_comb begin
    state_next      = state;
    act_next        = act;
    key_r_next      = key_r;
    rd_idx_next     = rd_idx;
    rd_step_next    = rd_step;
    clr_idx_next    = clr_idx;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    out_valid_next  = out_valid && !out_ready;
    status_next     = status;
    slot_next       = slot;
    in_ready        = 1'b0;
    hash_start      = 1'b0;
    mem_we          = 1'b0;
    mem_addr        = rd_idx;
    mem_wdata       = {1'b0, key_r};

    case (state)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_addr     = clr_idx;
        mem_wdata    = '0;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          act_next   = action;
          key_r_next = key;
          if (action == ACT_INSERT || action == ACT_DELETE || action == ACT_SEARCH) begin
            hash_start = 1'b1;
            state_next = S_HASH;
          end else begin
            res_status_next = STAT_NOT_FOUND;
            res_slot_next   = '0;
            state_next      = S_RESP;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          mem_addr     = hash_home;
          rd_idx_next  = hash_home;
          rd_step_next = '0;
          state_next   = S_PROBE;
        end
      end
      S_PROBE: begin
        if (hit) begin
          res_status_next = STAT_OK;
          res_slot_next   = SLOT_W'(rd_idx);
          mem_addr        = rd_idx;
          if (act == ACT_INSERT) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, key_r};
          end else if (act == ACT_DELETE) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b0, key_r};
          end
          state_next = S_RESP;
        end else if (last) begin
          res_status_next = (act == ACT_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
          res_slot_next   = '0;
          state_next      = S_RESP;
        end else begin
          // Read the following slot while this one is being checked.
          mem_addr     = next_idx;
          rd_idx_next  = next_idx;
          rd_step_next = rd_step + 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          status_next    = res_status;
          slot_next      = res_slot;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    act        <= act_next;
    key_r      <= key_r_next;
    rd_idx     <= rd_idx_next;
    rd_step    <= rd_step_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    status     <= status_next;
    slot       <= slot_next;
  end

  // Checks on the sequencer.
  `LPHT_ASSERT_IMP(a_we_phase, mem_we, state == S_CLEAR || state == S_PROBE, "RAM written outside clear or probe")
  `LPHT_ASSERT_IMP(a_hash_phase, hash_done, state == S_HASH, "home slot ready outside the hash state")
  `LPHT_ASSERT_IMP(a_slot_zero, out_valid && status != STAT_OK, slot == '0, "nonzero slot on a failed item")
  `LPHT_ASSERT_NXT(a_resp_load, state == S_RESP && out_free, out_valid && state == S_IDLE, "result not presented")

endmodule

[tb/linear_probing_hash_table_core_tb.sv]
// Self-checking testbench for the linear probing hash table core.
// A directed table of requests and then random request runs are checked against a local model or fixed results.
// Depends on lpht_pkg and linear_probing_hash_table_core.
`timescale 1ns / 1ps

module linear_probing_hash_table_core_tb;
  import lpht_pkg::*;

  localparam int TABLE_SIZE = 16;
  localparam int ITEMS_PER_PHASE = 500;

  // Action code with no meaning to the core; it must give a not-found result.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // Row markers for the directed table.
  localparam logic FIXED      = 1'b1;
  localparam logic FROM_MODEL = 1'b0;

  // Kinds of random run.
  localparam int RUN_FILL  = 0;
  localparam int RUN_DRAIN = 1;
  localparam int RUN_MIXED = 2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } lookup_result_t;

  typedef struct packed {
    logic [ACT_W-1:0]    act;
    logic [KEY_W-1:0]    k;
    logic                has_fixed;
    logic [STATUS_W-1:0] fixed_status;
    logic [SLOT_W-1:0]   fixed_slot;
  } request_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [ACT_W-1:0]    action;
  logic [KEY_W-1:0]    key;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;

  // Local copy of the table contents.
  logic [KEY_W-1:0] table_keys [TABLE_SIZE];
  logic             table_live [TABLE_SIZE];

  lookup_result_t pending_results [$];
  request_row_t   directed_rows [25];
  int             fail_count;
  int             send_idle_pct;
  int             recv_stall_pct;

  linear_probing_hash_table_core #(
    .TABLE_SIZE(TABLE_SIZE)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .key      (key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .slot     (slot)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Walks the local table for one request, updates it and returns the lookup outcome.
  function automatic lookup_result_t apply_request(input logic [ACT_W-1:0] act,
                                                   input logic [KEY_W-1:0] k);
    lookup_result_t r;
    int home;
    int idx;
    r.status = STAT_NOT_FOUND;
    r.slot   = '0;
    home     = int'(k % TABLE_SIZE);
    if (act == ACT_INSERT) begin
      r.status = STAT_FULL;
      for (int step = 0; step < TABLE_SIZE; step++) begin
        idx = (home + step) % TABLE_SIZE;
        if (!table_live[idx]) begin
          table_keys[idx] = k;
          table_live[idx] = 1'b1;
          r.status = STAT_OK;
          r.slot   = SLOT_W'(idx);
          return r;
        end
      end
    end else if (act == ACT_DELETE || act == ACT_SEARCH) begin
      for (int step = 0; step < TABLE_SIZE; step++) begin
        idx = (home + step) % TABLE_SIZE;
        if (table_live[idx] && table_keys[idx] == k) begin
          if (act == ACT_DELETE) begin
            table_live[idx] = 1'b0;
          end
          r.status = STAT_OK;
          r.slot   = SLOT_W'(idx);
          return r;
        end
      end
    end
    return r;
  endfunction

  // Picks a key for a random request; live keys give hits, the clustered pool gives collisions.
  function automatic logic [KEY_W-1:0] choose_key(input int live_pct);
    int live_total;
    int pick;
    int roll;
    live_total = 0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (table_live[i]) live_total++;
    end
    roll = $urandom_range(99);
    if (roll < live_pct && live_total > 0) begin
      pick = $urandom_range(live_total - 1);
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (table_live[i]) begin
          if (pick == 0) return table_keys[i];
          pick--;
        end
      end
    end
    roll = $urandom_range(99);
    if (roll < 55) begin
      // Homes around the end of the table so that probes wrap.
      return {28'($urandom_range(7)), 4'(($urandom_range(3) + 14) % 16)};
    end else if (roll < 62) begin
      return $urandom_range(1) ? '1 : '0;
    end
    return $urandom();
  endfunction

  // Counts a mismatch and prints it on one line.
  task automatic report_mismatch(input string what);
    fail_count++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Presents one request, holds it until taken and records what it should return.
  task automatic send_request(input request_row_t row);
    lookup_result_t predicted;
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    action   = row.act;
    key      = row.k;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = apply_request(row.act, row.k);
    if (row.has_fixed) begin
      pending_results.push_back({row.fixed_status, row.fixed_slot});
    end else begin
      pending_results.push_back(predicted);
    end
  endtask

  // Lowers valid and waits until every outstanding item has returned.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random runs: fill runs are mostly inserts, drain runs mostly deletes, mixed runs mix all actions.
  task automatic run_random(input int count);
    request_row_t row;
    int sent;
    int run_len;
    int run_kind;
    int roll;
    sent = 0;
    while (sent < count) begin
      run_len  = $urandom_range(20, 4);
      run_kind = $urandom_range(2);
      for (int j = 0; j < run_len && sent < count; j++) begin
        roll = $urandom_range(99);
        row  = '0;
        case (run_kind)
          RUN_FILL: begin
            row.act = (roll < 85) ? ACT_INSERT : (roll < 97) ? ACT_SEARCH : ACT_UNUSED;
            row.k   = choose_key(30);
          end
          RUN_DRAIN: begin
            row.act = (roll < 80) ? ACT_DELETE : ACT_SEARCH;
            row.k   = choose_key(80);
          end
          default: begin
            row.act = (roll < 40) ? ACT_INSERT : (roll < 68) ? ACT_DELETE :
                      (roll < 95) ? ACT_SEARCH : ACT_UNUSED;
            row.k   = choose_key(50);
          end
        endcase
        send_request(row);
        sent++;
      end
    end
  endtask

  // Result side: ready changes on the falling edge, items are checked on the rising edge.
  initial begin
    lookup_result_t want;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      @(posedge clk);
      if (rst === 1'b0 && out_valid === 1'b1 && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: status %0d slot %0d",
                                    status, slot));
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
          end
          if (slot !== want.slot) begin
            report_mismatch($sformatf("slot %0d, expected %0d", slot, want.slot));
          end
        end
      end
    end
  end

  // Main sequence: reset, directed table, then four idling phases of random runs.
  initial begin
    fail_count     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    action         = ACT_SEARCH;
    key            = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      table_keys[i] = '0;
      table_live[i] = 1'b0;
    end

    directed_rows = '{
      // Empty table: every lookup misses and the unused code does nothing.
      '{ACT_SEARCH, 32'h0000_0000, FIXED, STAT_NOT_FOUND, 4'd0},
      '{ACT_DELETE, 32'hFFFF_FFFF, FIXED, STAT_NOT_FOUND, 4'd0},
      '{ACT_UNUSED, 32'h5555_5555, FIXED, STAT_NOT_FOUND, 4'd0},
      // Extreme keys land in their home slots.
      '{ACT_INSERT, 32'h0000_0000, FIXED, STAT_OK, 4'd0},
      '{ACT_INSERT, 32'hFFFF_FFFF, FIXED, STAT_OK, 4'd15},
      // Collision at the last slot wraps round; a duplicate key is stored again.
      '{ACT_INSERT, 32'h0000_000F, FROM_MODEL, STAT_OK, 4'd0},
      '{ACT_INSERT, 32'h0000_0000, FROM_MODEL, STAT_OK, 4'd0},
      '{ACT_SEARCH, 32'h0000_000F, FROM_MODEL, STAT_OK, 4'd0},
      // Delete takes the first copy, so search then finds the second.
      '{ACT_DELETE, 32'h0000_0000, FROM_MODEL, STAT_OK, 4'd0},
      '{ACT_SEARCH, 32'h0000_0000, FROM_MODEL, STAT_OK, 4'd0},
      // Fill every remaining slot.
      '{ACT_INSERT, 32'hAAAA_AAAA, FROM_MODEL, STAT_OK, 4'd0},
      '{ACT_INSERT, 32'h8000_0000, FROM_MODEL, STAT_OK, 4'd0},
      '{ACT_INSERT, 32'h7FFF_FFF3, FROM_MODEL, STAT_OK, 4'd0},
      '{ACT_INSERT, 32'h0000_0010, FROM_MODEL, STAT_OK, 4'd0},
      '{ACT_INSERT, 32'h1234_5674, FROM_MODEL, STAT_OK, 4'd0},
      '{ACT_INSERT, 32'hDEAD_BEEF, FROM_MODEL, STAT_OK, 4'd0},
      '{ACT_INSERT, 32'h0000_0006, FROM_MODEL, STAT_OK, 4'd0},
      '{ACT_INSERT, 32'h0F0F_0F07, FROM_MODEL, STAT_OK, 4'd0},
      '{ACT_INSERT, 32'hF0F0_F0F8, FROM_MODEL, STAT_OK, 4'd0},
      '{ACT_INSERT, 32'h0000_0009, FROM_MODEL, STAT_OK, 4'd0},
      '{ACT_INSERT, 32'h1111_111B, FROM_MODEL, STAT_OK, 4'd0},
      '{ACT_INSERT, 32'h2222_222C, FROM_MODEL, STAT_OK, 4'd0},
      '{ACT_INSERT, 32'h3333_333D, FROM_MODEL, STAT_OK, 4'd0},
      // Full table: insert is refused and a missing key probes every slot.
      '{ACT_INSERT, 32'h5555_5555, FIXED, STAT_FULL, 4'd0},
      '{ACT_SEARCH, 32'h4444_4444, FROM_MODEL, STAT_OK, 4'd0}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i]);
    end

    // No idling at all.
    run_random(ITEMS_PER_PHASE);
    drain_results();

    // Sender mostly idle.
    send_idle_pct = 84;
    run_random(ITEMS_PER_PHASE);
    drain_results();

    // Receiver mostly stalling.
    send_idle_pct  = 0;
    recv_stall_pct = 84;
    run_random(ITEMS_PER_PHASE);
    drain_results();

    // Both sides idle now and then.
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    run_random(ITEMS_PER_PHASE);
    drain_results();

    // Allow time for any stray result to show up.
    repeat (TABLE_SIZE + 40) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
